// ----- sv/hfsr_pkg.sv -----
// Shared types and constants for the hex framed serial receiver.
`default_nettype none

package hfsr_pkg;

   // Frame header pair and reply bytes.
   localparam logic [7:0] HDR_FIRST  = 8'd12;
   localparam logic [7:0] HDR_SECOND = 8'd10;
   localparam logic [7:0] REPLY_ACK  = 8'd6;
   localparam logic [7:0] REPLY_NAK0 = 8'd2;
   localparam logic [7:0] REPLY_NAK1 = 8'd1;

   // Size field is five bytes, the first four of them hex digits.
   localparam logic [15:0] SIZE_BYTES   = 16'd5;
   localparam logic [15:0] DIGIT_BYTES  = 16'd4;
   localparam logic [15:0] HEADER_SEED  = 16'd22;

   // ASCII hex digit decode constants.
   localparam logic [7:0]  DIGIT_LIMIT  = 8'd58;
   localparam logic [15:0] DIGIT_BASE   = 16'd48;
   localparam logic [15:0] LETTER_BASE  = 16'd55;

   // Width of the result stream data word.
   localparam int RSP_DATA_W = 32;

   // What a queued event turns into on the result side.
   localparam logic [1:0] EV_PAYLOAD = 2'd0;
   localparam logic [1:0] EV_ACK     = 2'd1;
   localparam logic [1:0] EV_NAK     = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  value;
      logic [15:0] index;
   } event_type;

   typedef struct packed {
      logic      valid;
      event_type ev;
   } queue_head_type;

endpackage

`default_nettype wire

// ----- sv/hfsr_front.sv -----
// Front end: frame parser that turns received payload and end bytes into queued events.
`default_nettype none

module hfsr_front
   import hfsr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        accept,
   input  wire logic [7:0]  rx_byte,
   output logic             push,
   output event_type        push_ev
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_SIZE = 2'd1;
   localparam logic [1:0] PH_DATA = 2'd2;
   localparam logic [1:0] PH_CSUM = 2'd3;

   logic [1:0]  phase_ff, phase_in;
   logic        pair_half_ff, pair_half_in;
   logic [7:0]  held_byte_ff, held_byte_in;
   logic [15:0] field_count_ff, field_count_in;
   logic [15:0] size_value_ff, size_value_in;
   logic [15:0] running_sum_ff, running_sum_in;
   logic [15:0] received_sum_ff, received_sum_in;

   logic [15:0] digit;
   logic [15:0] byte_ext;
   logic [15:0] count_plus;
   logic [15:0] sum_plus;

   assign byte_ext   = {8'd0, rx_byte};
   assign digit      = (rx_byte < DIGIT_LIMIT) ? (byte_ext - DIGIT_BASE)
                                               : (byte_ext - LETTER_BASE);
   assign count_plus = field_count_ff + 16'd1;
   assign sum_plus   = running_sum_ff + byte_ext;

   always_comb begin
      phase_in        = phase_ff;
      pair_half_in    = pair_half_ff;
      held_byte_in    = held_byte_ff;
      field_count_in  = field_count_ff;
      size_value_in   = size_value_ff;
      running_sum_in  = running_sum_ff;
      received_sum_in = received_sum_ff;
      push            = 1'b0;
      push_ev.kind    = EV_PAYLOAD;
      push_ev.value   = rx_byte;
      push_ev.index   = field_count_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_SIZE: begin
               running_sum_in = sum_plus;
               if (field_count_ff < DIGIT_BYTES) begin
                  size_value_in = {size_value_ff[11:0], 4'd0} + digit;
               end
               field_count_in = count_plus;
               if (count_plus >= SIZE_BYTES) begin
                  field_count_in = 16'd0;
                  // The size digits are complete by now, so size_value_ff is final.
                  if (size_value_ff < SIZE_BYTES) begin
                     phase_in     = PH_IDLE;
                     pair_half_in = 1'b0;
                  end else if (size_value_ff == SIZE_BYTES) begin
                     received_sum_in = 16'd0;
                     phase_in        = PH_CSUM;
                  end else begin
                     phase_in = PH_DATA;
                  end
               end
            end
            PH_DATA: begin
               running_sum_in = sum_plus;
               push           = 1'b1;
               field_count_in = count_plus;
               if (count_plus >= size_value_ff - SIZE_BYTES) begin
                  field_count_in  = 16'd0;
                  received_sum_in = 16'd0;
                  phase_in        = PH_CSUM;
               end
            end
            PH_CSUM: begin
               if (field_count_ff < DIGIT_BYTES) begin
                  received_sum_in = {received_sum_ff[11:0], 4'd0} + digit;
                  field_count_in  = count_plus;
               end else begin
                  phase_in       = PH_IDLE;
                  pair_half_in   = 1'b0;
                  field_count_in = 16'd0;
                  running_sum_in = 16'd0;
                  push           = 1'b1;
                  push_ev.kind   = (running_sum_ff == received_sum_ff) ? EV_ACK : EV_NAK;
                  push_ev.index  = 16'd0;
               end
            end
            PH_IDLE: begin
               if (!pair_half_ff) begin
                  held_byte_in = rx_byte;
                  pair_half_in = 1'b1;
               end else begin
                  pair_half_in   = 1'b0;
                  running_sum_in = 16'd0;
                  if (held_byte_ff == HDR_FIRST && rx_byte == HDR_SECOND) begin
                     running_sum_in = HEADER_SEED;
                     size_value_in  = 16'd0;
                     field_count_in = 16'd0;
                     phase_in       = PH_SIZE;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         pair_half_ff    <= 1'b0;
         held_byte_ff    <= 8'd0;
         field_count_ff  <= 16'd0;
         size_value_ff   <= 16'd0;
         running_sum_ff  <= 16'd0;
         received_sum_ff <= 16'd0;
      end else begin
         phase_ff        <= phase_in;
         pair_half_ff    <= pair_half_in;
         held_byte_ff    <= held_byte_in;
         field_count_ff  <= field_count_in;
         size_value_ff   <= size_value_in;
         running_sum_ff  <= running_sum_in;
         received_sum_ff <= received_sum_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/hfsr_queue.sv -----
// Small event queue between the frame parser and the result stage.
`default_nettype none

module hfsr_queue
   import hfsr_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  event_type      push_ev,
   input  wire logic      pop,
   output queue_head_type head,
   output logic           full
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   event_type        entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == FULL_CNT);
   assign head.valid = (count_ff != '0);
   assign head.ev    = entries_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_ev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/hfsr_back.sv -----
// Result stage: expands queued events into result transfers with an output register.
`default_nettype none

module hfsr_back
   import hfsr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  queue_head_type   head,
   output logic             pop,
   output logic             out_valid,
   input  wire logic        out_ready,
   output logic             out_event,
   output logic [7:0]       out_value,
   output logic [15:0]      out_index,
   output logic             out_ok,
   output logic             out_last
);

   logic        valid_ff, valid_in;
   logic        second_ff, second_in;
   logic        event_ff, event_in;
   logic [7:0]  value_ff, value_in;
   logic [15:0] index_ff, index_in;
   logic        ok_ff, ok_in;
   logic        last_ff, last_in;
   logic        load;

   assign load = !valid_ff || out_ready;

   always_comb begin
      valid_in  = valid_ff;
      second_in = second_ff;
      event_in  = event_ff;
      value_in  = value_ff;
      index_in  = index_ff;
      ok_in     = ok_ff;
      last_in   = last_ff;
      pop       = 1'b0;
      if (load) begin
         valid_in = head.valid;
         if (head.valid) begin
            index_in = head.ev.index;
            unique case (head.ev.kind)
               EV_PAYLOAD: begin
                  event_in = 1'b0;
                  value_in = head.ev.value;
                  ok_in    = 1'b0;
                  last_in  = 1'b1;
                  pop      = 1'b1;
               end
               EV_ACK: begin
                  event_in = 1'b1;
                  value_in = REPLY_ACK;
                  ok_in    = 1'b1;
                  last_in  = 1'b1;
                  pop      = 1'b1;
               end
               EV_NAK: begin
                  // A failed frame answers with two reply bytes; the entry stays
                  // queued until the second one is loaded.
                  event_in  = 1'b1;
                  ok_in     = 1'b0;
                  value_in  = second_ff ? REPLY_NAK1 : REPLY_NAK0;
                  last_in   = second_ff;
                  pop       = second_ff;
                  second_in = !second_ff;
               end
               default: begin
                  valid_in = 1'b0;
                  pop      = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      event_ff <= event_in;
      value_ff <= value_in;
      index_ff <= index_in;
      ok_ff    <= ok_in;
      last_ff  <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_event = event_ff;
   assign out_value = value_ff;
   assign out_index = index_ff;
   assign out_ok    = ok_ff;
   assign out_last  = last_ff;

endmodule

`default_nettype wire

// ----- sv/hex_framed_serial_receiver_top.sv -----
// Top level of the hex framed serial receiver.
//
// The req channel takes one received byte per transfer. Outside a frame the
// bytes are read in pairs until the pair 0x0C 0x0A opens a frame; four hex
// size digits and a fifth size byte follow, then the payload, four hex
// checksum digits and an end byte. Every payload byte comes out on the rsp
// channel with its index (tuser 0). The end byte yields the reply: one
// transfer with 6 on a good checksum, or two transfers 2 then 1 on a bad one
// (tuser 1); tlast marks the final result caused by an input byte.
// A byte is taken every cycle while the event queue has room, so throughput
// is one byte per cycle; a failed frame's reply uses two output transfers.
// A result passes through the queue and the output register to reach rsp.
// When the rsp side stalls, the output register holds and the queue of
// QUEUE_DEPTH events fills; req_tready drops only when the queue is full.
// Reset is synchronous and returns the parser to pair hunting with an empty
// queue and no result pending.
`default_nettype none

module hex_framed_serial_receiver_top
   import hfsr_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,   // [7:0] rx_byte
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // [7:0] value, [23:8] payload_index,
                                                   // [24] frame_ok, rest zero
   output logic                       rsp_tuser,   // [0] event_res
   output logic                       rsp_tlast
);

   logic           accept;
   logic           push;
   event_type      push_ev;
   logic           pop;
   logic           full;
   queue_head_type head;
   logic [7:0]     out_value;
   logic [15:0]    out_index;
   logic           out_ok;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   hfsr_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_tdata),
      .push    (push),
      .push_ev (push_ev)
   );

   hfsr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_ev (push_ev),
      .pop     (pop),
      .head    (head),
      .full    (full)
   );

   hfsr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_event (rsp_tuser),
      .out_value (out_value),
      .out_index (out_index),
      .out_ok    (out_ok),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {(RSP_DATA_W - 25)'(0), out_ok, out_index, out_value};

endmodule

`default_nettype wire

// ----- sv/hfsr_checker.sv -----
// Port-level assertions for the hex framed serial receiver, bound to the top level.
`default_nettype none

module hfsr_checker
   import hfsr_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tuser,
   input wire logic                  rsp_tlast
);

   // Nothing is offered on the result side right after a reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A stalled result transfer keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Payload results are always the last result of their byte and never flag success.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast && !rsp_tdata[24])
      else $error("payload result with bad tlast or frame_ok");

   // The first reply byte of a failed frame is followed at once by the second one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser && rsp_tdata[7:0] == REPLY_NAK0
      |-> !rsp_tlast ##1 (rsp_tvalid && rsp_tuser && rsp_tlast
                          && rsp_tdata[7:0] == REPLY_NAK1 && !rsp_tdata[24]))
      else $error("failed frame reply out of order");

endmodule

bind hex_framed_serial_receiver_top hfsr_checker u_hfsr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
